// ===== rtl/core/mxt_pkg.sv =====
package mxt_pkg;

  localparam int KEY_BITS   = 32;
  localparam int POOL_NODES = 4096;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int USED_W = $clog2(POOL_NODES + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int INIT_W = $clog2(KEY_BITS + 2);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_XOR    = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] c1;
    logic [NODE_W-1:0] c0;
  } mxt_entry_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    mxt_entry_t        wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } mxt_mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] min_xor;
    logic             status;
  } mxt_res_t;

endpackage

// ===== rtl/core/mxt_node_mem.sv =====
module mxt_node_mem (
  input  logic                 clk,
  input  mxt_pkg::mxt_mem_req_t req,
  output mxt_pkg::mxt_entry_t   rdata
);

  mxt_pkg::mxt_entry_t mem [mxt_pkg::POOL_NODES];
  mxt_pkg::mxt_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mxt_ctrl.sv =====
module mxt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    func,
  input  logic [mxt_pkg::IN_W-1:0]      operand_value,
  input  logic                          res_take,
  output logic                          ready,
  output mxt_pkg::mxt_res_t             res,
  output mxt_pkg::mxt_mem_req_t         mem_req,
  input  mxt_pkg::mxt_entry_t           mem_rdata
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int KB = mxt_pkg::KEY_BITS;
  localparam int NW = mxt_pkg::NODE_W;
  localparam int UW = mxt_pkg::USED_W;
  localparam int LW = mxt_pkg::LVL_W;
  localparam int IW = mxt_pkg::INIT_W;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] init_cnt_r, init_cnt_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [KB-1:0] key_r, key_nxt;
  logic [KB-1:0] mask_r, mask_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [NW-1:0] new_r, new_nxt;
  logic [KB-1:0] ans_r, ans_nxt;
  logic          stat_r, stat_nxt;

  logic          sel;
  logic [NW-1:0] child_a, child_b;
  logic [LW-1:0] lvl_dn;
  logic [UW:0]   room_sum;
  logic          full;
  mxt_pkg::mxt_entry_t ent;

  assign lvl_dn   = lvl_r - 1'b1;
  assign sel      = (func_r == mxt_pkg::FUNC_INSERT) ? key_r[lvl_r] : mask_r[lvl_r];
  assign child_a  = sel ? mem_rdata.c1 : mem_rdata.c0;
  assign child_b  = sel ? mem_rdata.c0 : mem_rdata.c1;
  assign room_sum = {1'b0, used_r} + (UW+1)'(lvl_r) + (UW+1)'(1);
  assign full     = room_sum > (UW+1)'(mxt_pkg::POOL_NODES);

  always_comb begin
    state_nxt    = state_r;
    init_cnt_nxt = init_cnt_r;
    lvl_nxt      = lvl_r;
    func_nxt     = func_r;
    key_nxt      = key_r;
    mask_nxt     = mask_r;
    node_nxt     = node_r;
    used_nxt     = used_r;
    new_nxt      = new_r;
    ans_nxt      = ans_r;
    stat_nxt     = stat_r;
    ent          = '0;
    mem_req      = '0;

    unique case (state_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = NW'(init_cnt_r);
        if (init_cnt_r < IW'(KB)) begin
          mem_req.wdata.c0 = NW'(init_cnt_r) + NW'(1);
        end
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == IW'(KB)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          func_nxt = func;
          key_nxt  = operand_value[KB-1:0] ^ mask_r;
          ans_nxt  = '0;
          stat_nxt = 1'b0;
          case (func)
            mxt_pkg::FUNC_INSERT, mxt_pkg::FUNC_QUERY: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              node_nxt      = '0;
              lvl_nxt       = LW'(KB - 1);
              state_nxt     = ST_WALK;
            end
            mxt_pkg::FUNC_XOR: begin
              mask_nxt  = mask_r ^ operand_value[KB-1:0];
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (func_r == mxt_pkg::FUNC_INSERT) begin
          if (child_a != '0) begin
            if (lvl_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = child_a;
              node_nxt      = child_a;
              lvl_nxt       = lvl_dn;
            end
          end else if (full) begin
            stat_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            ent = mem_rdata;
            if (sel) begin
              ent.c1 = used_r[NW-1:0];
            end else begin
              ent.c0 = used_r[NW-1:0];
            end
            mem_req.we    = 1'b1;
            mem_req.waddr = node_r;
            mem_req.wdata = ent;
            new_nxt       = used_r[NW-1:0];
            used_nxt      = used_r + 1'b1;
            state_nxt     = ST_ALLOC;
          end
        end else begin
          if (child_a == '0) begin
            ans_nxt[lvl_r] = 1'b1;
          end
          if ((child_a == '0 && child_b == '0) || lvl_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = (child_a != '0) ? child_a : child_b;
            lvl_nxt       = lvl_dn;
          end
        end
      end
      ST_ALLOC: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = new_r;
        if (lvl_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          if (key_r[lvl_dn]) begin
            ent.c1 = used_r[NW-1:0];
          end else begin
            ent.c0 = used_r[NW-1:0];
          end
          new_nxt  = used_r[NW-1:0];
          used_nxt = used_r + 1'b1;
          lvl_nxt  = lvl_dn;
        end
        mem_req.wdata = ent;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      init_cnt_r <= '0;
      mask_r     <= '0;
      used_r     <= UW'(KB + 1);
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      mask_r     <= mask_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r  <= lvl_nxt;
    func_r <= func_nxt;
    key_r  <= key_nxt;
    node_r <= node_nxt;
    new_r  <= new_nxt;
    ans_r  <= ans_nxt;
    stat_r <= stat_nxt;
  end

  assign ready       = (state_r == ST_IDLE);
  assign res.valid   = (state_r == ST_DONE);
  assign res.min_xor = mxt_pkg::OUT_W'(ans_r);
  assign res.status  = stat_r;

endmodule

// ===== rtl/core/min_xor_binary_trie_unit.sv =====
// Minimum-XOR binary trie. Keeps a set of keys (key 0 from reset) in a node
// memory plus a running XOR mask. func 0 inserts operand XOR mask (status 1 if
// the pool cannot hold the whole new path; trie left unchanged), func 1 folds
// the operand into the mask, func 2 returns the minimum of key XOR mask. One
// transaction in flight at a time: the trie walk reads one level per cycle
// from the single node memory. An insert that adds nodes then writes the
// missing levels one per cycle, and a rejected one writes nothing, as the
// walk stops at the first missing level. A mask update or unused code makes
// no memory access. A result is held until the output can take it. After
// reset the key-zero chain is written, during which in_stall is high.
module min_xor_binary_trie_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [mxt_pkg::IN_W-1:0]   in_operand_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mxt_pkg::OUT_W-1:0]  out_min_xor,
  output logic                       out_status
);

  logic                     ready;
  logic                     res_take;
  mxt_pkg::mxt_res_t        res;
  mxt_pkg::mxt_mem_req_t    mem_req;
  mxt_pkg::mxt_entry_t      mem_rdata;

  logic                     out_valid_r, out_valid_nxt;
  logic [mxt_pkg::OUT_W-1:0] out_min_xor_r;
  logic                     out_status_r;

  assign in_stall = !ready;
  assign res_take = !out_valid_r || !out_stall;

  mxt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && ready),
    .func         (in_func),
    .operand_value(in_operand_value),
    .res_take     (res_take),
    .ready        (ready),
    .res          (res),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  mxt_node_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_min_xor_r <= res.min_xor;
      out_status_r  <= res.status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_min_xor = out_min_xor_r;
  assign out_status  = out_status_r;

endmodule
